[hdl/kmbd_pkg.sv]
package kmbd_pkg;

	localparam int QUEUE_DEPTH_DEF = 256;
	localparam int CMD_DEPTH       = 2;

	localparam logic [9:0] MAX_X_RST = 10'd632;
	localparam logic [9:0] MAX_Y_RST = 10'd392;

	localparam logic [7:0] MOUSE_MIN = 8'hF8;

	localparam logic [1:0] FUNC_RX    = 2'd0;
	localparam logic [1:0] FUNC_POP   = 2'd1;
	localparam logic [1:0] FUNC_QUERY = 2'd2;

	localparam logic REG_MAX_X = 1'b0;
	localparam logic REG_MAX_Y = 1'b1;

	typedef enum logic [1:0] {
		PKT_IDLE,
		PKT_DX,
		PKT_DY
	} pkt_state_t;

	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_MOVE,
		CMD_BREAK,
		CMD_MAKE,
		CMD_POP,
		CMD_QUERY
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [6:0] code;
		logic [7:0] dx;
		logic [7:0] dy;
		logic       btn;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

endpackage

[hdl/kmbd_front.sv]
module kmbd_front import kmbd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [1:0] func,
	input  logic [7:0] data,
	input  fifo_stat_t fstat,
	output logic       cmd_push,
	output cmd_t       cmd
);

	pkt_state_t pkt_state_q, pkt_state_d;
	logic       hdr_btn_q;
	logic [7:0] dx_q;
	logic       mouse_byte;

	assign item_ready = !fstat.full;
	assign cmd_push   = item_valid && item_ready;
	assign mouse_byte = (func == FUNC_RX) && ((pkt_state_q != PKT_IDLE) || (data >= MOUSE_MIN));

	// next state
	always_comb begin
		pkt_state_d = pkt_state_q;
		if (mouse_byte) begin
			unique case (pkt_state_q)
				PKT_IDLE: pkt_state_d = PKT_DX;
				PKT_DX:   pkt_state_d = PKT_DY;
				PKT_DY:   pkt_state_d = PKT_IDLE;
				default:  pkt_state_d = PKT_IDLE;
			endcase
		end
	end

	// command classification
	always_comb begin
		cmd.kind = CMD_NOP;
		cmd.code = data[6:0];
		cmd.dx   = dx_q;
		cmd.dy   = data;
		cmd.btn  = hdr_btn_q;
		unique case (func)
			FUNC_RX: begin
				if (mouse_byte) begin
					cmd.kind = (pkt_state_q == PKT_DY) ? CMD_MOVE : CMD_NOP;
				end else if (data[7]) begin
					cmd.kind = CMD_BREAK;
				end else begin
					cmd.kind = CMD_MAKE;
				end
			end
			FUNC_POP:   cmd.kind = CMD_POP;
			FUNC_QUERY: cmd.kind = data[7] ? CMD_NOP : CMD_QUERY;
			default:    cmd.kind = CMD_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_state_q <= PKT_IDLE;
		end else if (cmd_push) begin
			pkt_state_q <= pkt_state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_push && mouse_byte && pkt_state_q == PKT_IDLE) begin
			hdr_btn_q <= data[1];
		end
		if (cmd_push && mouse_byte && pkt_state_q == PKT_DX) begin
			dx_q <= data;
		end
	end

endmodule

[hdl/kmbd_cmd_fifo.sv]
module kmbd_cmd_fifo import kmbd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cmd_t       push_cmd,
	input  logic       pop,
	output cmd_t       head,
	output logic       head_valid,
	output fifo_stat_t fstat
);

	localparam int AW = $clog2(CMD_DEPTH);
	localparam int CW = $clog2(CMD_DEPTH + 1);

	cmd_t          entries_q [CMD_DEPTH];
	logic [AW-1:0] rd_ptr_q, wr_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign fstat.empty = (count_q == '0);
	assign fstat.full  = (count_q == CW'(CMD_DEPTH));
	assign head_valid  = !fstat.empty;
	assign head        = entries_q[rd_ptr_q];
	assign do_push     = push && !fstat.full;
	assign do_pop      = pop && !fstat.empty;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(CMD_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			count_q <= count_q + CW'(do_push) - CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

[hdl/kmbd_back.sv]
module kmbd_back import kmbd_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [9:0] max_x,
	input  logic [9:0] max_y,
	input  cmd_t       cmd,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [6:0] popped_code,
	output logic       key_held,
	output logic [9:0] pointer_x,
	output logic [9:0] pointer_y,
	output logic       button_down,
	output logic       keystroke_pending
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [6:0]    mem [QUEUE_DEPTH];
	logic [AW-1:0] rd_ptr_q, wr_ptr_q;
	logic [CW-1:0] count_q, count_d;
	logic [127:0]  held_q;
	logic [9:0]    pos_x_q, pos_y_q, pos_x_d, pos_y_d;
	logic          btn_q, btn_d;
	logic          valid_q;
	logic          take, do_push, do_pop, is_move;
	logic [11:0]   sum_x, sum_y;
	logic [6:0]    pop_data_q;
	logic          res_pop_q, res_held_q, res_btn_q, res_pend_q;
	logic [9:0]    res_x_q, res_y_q;

	assign cmd_ready = !valid_q || result_ready;
	assign take      = cmd_valid && cmd_ready;
	assign is_move   = take && (cmd.kind == CMD_MOVE);
	assign do_push   = take && (cmd.kind == CMD_MAKE) && (count_q != CW'(QUEUE_DEPTH));
	assign do_pop    = take && (cmd.kind == CMD_POP) && (count_q != '0);
	assign count_d   = count_q + CW'(do_push) - CW'(do_pop);

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [9:0] clamp(input logic [11:0] s, input logic [9:0] lim);
		logic [9:0] r;
		if (s[11]) begin
			r = '0;
		end else if (s[10:0] > {1'b0, lim}) begin
			r = lim;
		end else begin
			r = s[9:0];
		end
		return r;
	endfunction

	always_comb begin
		sum_x   = {2'b00, pos_x_q} + {{4{cmd.dx[7]}}, cmd.dx};
		sum_y   = {2'b00, pos_y_q} + {{4{cmd.dy[7]}}, cmd.dy};
		pos_x_d = is_move ? clamp(sum_x, max_x) : pos_x_q;
		pos_y_d = is_move ? clamp(sum_y, max_y) : pos_y_q;
		btn_d   = is_move ? cmd.btn : btn_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
			held_q   <= '0;
			pos_x_q  <= '0;
			pos_y_q  <= '0;
			btn_q    <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			count_q <= count_d;
			pos_x_q <= pos_x_d;
			pos_y_q <= pos_y_d;
			btn_q   <= btn_d;
			if (take && cmd.kind == CMD_MAKE)  held_q[cmd.code] <= 1'b1;
			if (take && cmd.kind == CMD_BREAK) held_q[cmd.code] <= 1'b0;
			if (take) begin
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem[wr_ptr_q] <= cmd.code;
		if (do_pop)  pop_data_q <= mem[rd_ptr_q];
		if (take) begin
			res_pop_q  <= do_pop;
			res_held_q <= (cmd.kind == CMD_QUERY) && held_q[cmd.code];
			res_x_q    <= pos_x_d;
			res_y_q    <= pos_y_d;
			res_btn_q  <= btn_d;
			res_pend_q <= (count_d != '0);
		end
	end

	assign result_valid      = valid_q;
	assign popped_code       = res_pop_q ? pop_data_q : '0;
	assign key_held          = res_held_q;
	assign pointer_x         = res_x_q;
	assign pointer_y         = res_y_q;
	assign button_down       = res_btn_q;
	assign keystroke_pending = res_pend_q;

endmodule

[hdl/keyboard_mouse_byte_decoder.sv]
// An item goes through the command queue, then the result register. Throughput: 1 item
// per cycle while result_ready is high; the back end retires one command per cycle into
// its result register, and the 2-entry command queue absorbs a stalled result side.
// Reset (arst_n low, asynchronous): key table, scan-code queue pointers, pointer
// position, button and packet state clear; max_x/max_y return to 632/392.
module keyboard_mouse_byte_decoder import kmbd_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_en,
	input  logic       cfg_addr,
	input  logic [9:0] cfg_data,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [1:0] func,
	input  logic [7:0] data,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [6:0] popped_code,
	output logic       key_held,
	output logic [9:0] pointer_x,
	output logic [9:0] pointer_y,
	output logic       button_down,
	output logic       keystroke_pending
);

	logic [9:0] max_x_q, max_y_q;
	cmd_t       front_cmd, head_cmd;
	logic       cmd_push, head_valid, back_ready;
	fifo_stat_t fstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_x_q <= MAX_X_RST;
			max_y_q <= MAX_Y_RST;
		end else if (cfg_en) begin
			unique case (cfg_addr)
				REG_MAX_X: max_x_q <= cfg_data;
				REG_MAX_Y: max_y_q <= cfg_data;
				default:   max_x_q <= max_x_q;
			endcase
		end
	end

	kmbd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.func       (func),
		.data       (data),
		.fstat      (fstat),
		.cmd_push   (cmd_push),
		.cmd        (front_cmd)
	);

	kmbd_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_push),
		.push_cmd   (front_cmd),
		.pop        (back_ready),
		.head       (head_cmd),
		.head_valid (head_valid),
		.fstat      (fstat)
	);

	kmbd_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.max_x             (max_x_q),
		.max_y             (max_y_q),
		.cmd               (head_cmd),
		.cmd_valid         (head_valid),
		.cmd_ready         (back_ready),
		.result_valid      (result_valid),
		.result_ready      (result_ready),
		.popped_code       (popped_code),
		.key_held          (key_held),
		.pointer_x         (pointer_x),
		.pointer_y         (pointer_y),
		.button_down       (button_down),
		.keystroke_pending (keystroke_pending)
	);

	a_idle_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && fstat.empty && !result_valid) |-> ##2 result_valid)
		else $error("item through idle pipe did not produce a result in 2 cycles");

	a_held_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && key_held) |-> (popped_code == '0))
		else $error("query result carries a popped code");

	a_rise_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!fstat.empty))
		else $error("result appeared without a queued command");

endmodule
